/* rtl/core/lpfs_pkg.sv */
package lpfs_pkg;

  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CHUNK_W    = 7;
  localparam int unsigned HDR_LEN_W  = 17;
  localparam int unsigned HDR_BYTES  = 3;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK   = 7'd64;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 7'd64;

  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_CHUNK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [COUNT_W-1:0] write_count;
    logic [7:0]         data_byte;
    logic               done_error;
  } in_req_t;

  typedef struct packed {
    logic    res_kind;
    status_e status;
    logic [7:0] chunk_byte;
    logic    chunk_last;
    logic    frame_cleared;
  } out_req_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic               is_chunk;
    status_e            status;
    logic               restart;
    logic [CHUNK_W-1:0] len;
    logic               clears;
  } cmd_t;

endpackage

/* rtl/core/lpfs_cmd_fifo.sv */
module lpfs_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpfs_pkg::cmd_t   cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lpfs_pkg::cmd_t   cmd_o
);

  lpfs_pkg::cmd_t entry_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= cmd_i;
    end
  end

endmodule

/* rtl/core/lpfs_front.sv */
module lpfs_front #(
  parameter int unsigned BUFFER_BYTES = 320,
  localparam int unsigned AW = $clog2(BUFFER_BYTES)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpfs_pkg::CHUNK_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lpfs_pkg::in_req_t               in_req_i,
  input  logic                            cmd_full_i,
  input  logic                            chunk_pending_i,
  output logic                            cmd_push_o,
  output lpfs_pkg::cmd_t                  cmd_o,
  output logic                            wr_en_o,
  output logic [AW-1:0]                   wr_addr_o,
  output logic [7:0]                      wr_data_o
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SW = ((CW > lpfs_pkg::COUNT_W) ? CW : lpfs_pkg::COUNT_W) + 1;
  localparam int unsigned EW = (CW > lpfs_pkg::HDR_LEN_W) ? CW : lpfs_pkg::HDR_LEN_W;
  localparam int unsigned CKW = lpfs_pkg::CHUNK_W;
  localparam int unsigned RW = lpfs_pkg::COUNT_W;

  logic [CKW-1:0]                 chunk_q, chunk_d;
  logic [CW-1:0]                  fill_q, fill_d;
  logic [CW-1:0]                  sent_q, sent_d;
  logic                           busy_q, busy_d;
  logic                           open_q, open_d;
  logic [lpfs_pkg::COUNT_W-1:0]   rem_q, rem_d;
  logic [7:0]                     hdr_lo_q, hdr_lo_d, hdr_hi_q, hdr_hi_d;

  logic           accept;
  logic [CKW-1:0] eff;
  logic [EW-1:0]  hdr_len, expected, e_len, rest, d_len, after;
  logic [SW-1:0]  begin_sum;
  logic           e_clears, d_clears;

  assign in_stall_o = (in_req_i.kind == lpfs_pkg::KIND_DATA) ? chunk_pending_i : cmd_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (chunk_q == '0) begin
      eff = CKW'(1);
    end else if (chunk_q > lpfs_pkg::MAX_CHUNK) begin
      eff = lpfs_pkg::MAX_CHUNK;
    end else begin
      eff = chunk_q;
    end
  end

  assign hdr_len   = EW'({hdr_hi_q, hdr_lo_q}) + EW'(lpfs_pkg::HDR_BYTES);
  assign expected  = (EW'(fill_q) >= EW'(lpfs_pkg::HDR_BYTES)) ? hdr_len : EW'(BUFFER_BYTES);
  assign e_len     = (expected < EW'(eff)) ? expected : EW'(eff);
  assign e_clears  = (e_len >= EW'(fill_q));
  assign rest      = (fill_q > sent_q) ? EW'(fill_q - sent_q) : '0;
  assign d_len     = (rest < EW'(eff)) ? rest : EW'(eff);
  assign after     = EW'(sent_q) + d_len;
  assign d_clears  = (after >= EW'(fill_q)) || (after >= hdr_len);
  assign begin_sum = SW'(in_req_i.write_count) + SW'(fill_q);

  always_comb begin
    chunk_d    = chunk_q;
    fill_d     = fill_q;
    sent_d     = sent_q;
    busy_d     = busy_q;
    open_d     = open_q;
    rem_d      = rem_q;
    hdr_lo_d   = hdr_lo_q;
    hdr_hi_d   = hdr_hi_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = fill_q[AW-1:0];
    wr_data_o  = in_req_i.data_byte;

    if (cfg_we_i) begin
      chunk_d = cfg_wdata_i;
    end

    if (accept) begin
      unique case (in_req_i.kind)
        lpfs_pkg::KIND_BEGIN: begin
          cmd_push_o = 1'b1;
          if (in_req_i.write_count == '0) begin
            cmd_o.status = lpfs_pkg::ST_EMPTY;
          end else if (busy_q || open_q) begin
            cmd_o.status = lpfs_pkg::ST_BUSY;
          end else if (begin_sum > SW'(BUFFER_BYTES)) begin
            fill_d       = '0;
            cmd_o.status = lpfs_pkg::ST_OVERFLOW;
          end else begin
            open_d       = 1'b1;
            rem_d        = in_req_i.write_count;
            cmd_o.status = lpfs_pkg::ST_OK;
          end
        end
        lpfs_pkg::KIND_DATA: begin
          if (open_q && (rem_q != '0) && (fill_q < CW'(BUFFER_BYTES))) begin
            wr_en_o = 1'b1;
            fill_d  = fill_q + CW'(1);
            rem_d   = rem_q - RW'(1);
            if (fill_q == CW'(1)) begin
              hdr_lo_d = in_req_i.data_byte;
            end
            if (fill_q == CW'(2)) begin
              hdr_hi_d = in_req_i.data_byte;
            end
          end
        end
        lpfs_pkg::KIND_END: begin
          if (open_q) begin
            open_d = 1'b0;
            rem_d  = '0;
            if (EW'(fill_q) >= expected) begin
              cmd_push_o     = 1'b1;
              cmd_o.is_chunk = 1'b1;
              cmd_o.restart  = 1'b1;
              cmd_o.len      = e_len[CKW-1:0];
              cmd_o.clears   = e_clears;
              sent_d         = e_len[CW-1:0];
              busy_d         = 1'b1;
              if (e_clears) begin
                fill_d   = '0;
                sent_d   = '0;
                hdr_lo_d = '0;
                hdr_hi_d = '0;
              end
            end
          end
        end
        lpfs_pkg::KIND_DONE: begin
          busy_d = 1'b0;
          if (!in_req_i.done_error && (fill_q != '0) && (d_len != '0)) begin
            cmd_push_o     = 1'b1;
            cmd_o.is_chunk = 1'b1;
            cmd_o.len      = d_len[CKW-1:0];
            cmd_o.clears   = d_clears;
            sent_d         = after[CW-1:0];
            busy_d         = 1'b1;
            if (d_clears) begin
              fill_d   = '0;
              sent_d   = '0;
              hdr_lo_d = '0;
              hdr_hi_d = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q  <= lpfs_pkg::CHUNK_RESET;
      fill_q   <= '0;
      sent_q   <= '0;
      busy_q   <= 1'b0;
      open_q   <= 1'b0;
      rem_q    <= '0;
      hdr_lo_q <= '0;
      hdr_hi_q <= '0;
    end else begin
      chunk_q  <= chunk_d;
      fill_q   <= fill_d;
      sent_q   <= sent_d;
      busy_q   <= busy_d;
      open_q   <= open_d;
      rem_q    <= rem_d;
      hdr_lo_q <= hdr_lo_d;
      hdr_hi_q <= hdr_hi_d;
    end
  end

endmodule

/* rtl/core/lpfs_back.sv */
module lpfs_back #(
  parameter int unsigned BUFFER_BYTES = 320,
  localparam int unsigned AW = $clog2(BUFFER_BYTES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  lpfs_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               busy_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [7:0]         wr_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpfs_pkg::out_req_t out_req_o
);

  localparam int unsigned CKW = lpfs_pkg::CHUNK_W;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_CHUNK = 2'b10
  } bk_state_e;

  bk_state_e          state_q, state_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [CKW-1:0]     left_q, left_d;
  logic               clears_q, clears_d;
  logic               rd_valid_q, rd_valid_d;
  logic               rd_last_q, rd_last_d;
  logic               rd_clear_q, rd_clear_d;
  logic [7:0]         rdata_q;
  logic               out_valid_q, out_valid_d;
  lpfs_pkg::out_req_t out_q, out_d;

  logic [7:0] mem [BUFFER_BYTES];

  logic out_load, issue, in_idle, final_byte;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_idle    = (state_q == BK_IDLE);
  assign cmd_pop_o  = in_idle && !rd_valid_q && cmd_valid_i && (cmd_i.is_chunk || out_load);
  assign issue      = (state_q == BK_CHUNK) && (!rd_valid_q || out_load);
  assign final_byte = (left_q == CKW'(1));
  assign busy_o     = !in_idle || rd_valid_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    clears_d    = clears_q;
    rd_valid_d  = rd_valid_q && !out_load;
    rd_last_d   = rd_last_q;
    rd_clear_d  = rd_clear_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.is_chunk) begin
            state_d  = BK_CHUNK;
            left_d   = cmd_i.len;
            clears_d = cmd_i.clears;
            if (cmd_i.restart) begin
              ptr_d = '0;
            end
          end else begin
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.res_kind = lpfs_pkg::RES_STATUS;
            out_d.status   = cmd_i.status;
          end
        end
      end
      BK_CHUNK: begin
        if (issue) begin
          rd_valid_d = 1'b1;
          rd_last_d  = final_byte;
          rd_clear_d = final_byte && clears_q;
          left_d     = left_q - CKW'(1);
          ptr_d      = (final_byte && clears_q) ? '0 : ptr_q + AW'(1);
          if (final_byte) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (rd_valid_q && out_load) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.res_kind      = lpfs_pkg::RES_CHUNK;
      out_d.status        = lpfs_pkg::ST_OK;
      out_d.chunk_byte    = rdata_q;
      out_d.chunk_last    = rd_last_q;
      out_d.frame_cleared = rd_clear_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ptr_q       <= '0;
      left_q      <= '0;
      clears_q    <= 1'b0;
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_clear_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      left_q      <= left_d;
      clears_q    <= clears_d;
      rd_valid_q  <= rd_valid_d;
      rd_last_q   <= rd_last_d;
      rd_clear_q  <= rd_clear_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rdata_q <= mem[ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* rtl/core/length_prefixed_frame_segmenter_core.sv */
// Frame segmenter: host write calls (begin, data bytes, end) fill a byte buffer of
// BUFFER_BYTES entries; once the length in header bytes 1..2 (plus 3) is met, the
// frame leaves in chunks of up to chunk_size bytes (at most 64): the first on the end
// request, then at most one per transfer-done request. Begin, end and done requests
// are accepted while the two-entry command queue has room; a data byte waits
// while the command queue holds anything or a chunk is still being read out,
// because chunks read the buffer that data bytes fill.
// Chunk bytes leave at one per cycle unless the output stalls, set by the buffer's
// single read port, through a read register and then the output register. Begin
// requests answer with one status request in order with the chunk bytes.
module length_prefixed_frame_segmenter_core #(
  parameter int unsigned BUFFER_BYTES = 320
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpfs_pkg::CHUNK_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpfs_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpfs_pkg::out_req_t            out_req_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic           cmd_push, cmd_full, cmd_valid, cmd_pop, back_busy;
  lpfs_pkg::cmd_t cmd_in, cmd_out;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;

  lpfs_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_req_i       (in_req_i),
    .cmd_full_i     (cmd_full),
    .chunk_pending_i(cmd_valid || back_busy),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  lpfs_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .cmd_o  (cmd_out)
  );

  lpfs_back #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .busy_o     (back_busy),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule

/* rtl/core/lpfs_checker.sv */
module lpfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input lpfs_pkg::out_req_t            out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("output request dropped or changed while stalled");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.res_kind == lpfs_pkg::RES_STATUS) |->
      (out_req_o.chunk_byte == 8'd0) && !out_req_o.chunk_last && !out_req_o.frame_cleared)
    else $error("status request carries chunk fields");

  a_chunk_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.res_kind == lpfs_pkg::RES_CHUNK) |->
      (out_req_o.status == lpfs_pkg::ST_OK))
    else $error("chunk byte carries a status");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.frame_cleared |-> out_req_o.chunk_last)
    else $error("frame cleared before the chunk's last byte");

endmodule

bind length_prefixed_frame_segmenter_core lpfs_checker u_lpfs_checker (.*);
